>>> hw/rtl/rswc_pkg.sv
// Shared types and constants for the rank-sum word count block.
// No dependencies; imported by every module of the block.
package rswc_pkg;

  localparam int COEF_W = 30;
  localparam int SIZE_W = 5;
  localparam int GAP_W  = 9;

  localparam logic [GAP_W-1:0] GAP_RESET = 9'd45;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [GAP_W-1:0]  gap_t;
  typedef logic [SIZE_W-1:0] size_t;

endpackage

>>> hw/rtl/rswc_cell.sv
// One coefficient cell of the shifting score chain.
// Depends on rswc_pkg for the coefficient type.
module rswc_cell import rswc_pkg::*; (
  input  logic  clk,
  input  logic  advance,
  input  coef_t d,
  output coef_t q
);

  always_ff @(posedge clk) begin
    if (advance) begin
      q <= d;
    end
  end

endmodule

>>> hw/rtl/rank_sum_word_count_extremes.sv
// Top level of the rank-sum word count block: control, update cell logic, totals.
// Depends on rswc_pkg and rswc_cell.
//
// Usage: pulse start with size_a and size_b while busy is low; the transfer
// happens at that edge and busy rises. Sizes above MAX_GROUP saturate.
// The score table lives in a ring of MAX_GROUP*MAX_GROUP+1 cells that shifts
// one place per cycle while a request runs. One pass rotates the ring once:
// a first pass loads the unit polynomial, then pass j multiplies by
// (1 - q^(b+j)) and divides by (1 - q^j) on the fly, with a history chain of
// 2*MAX_GROUP cells for the delayed input taps. The last pass also sums the
// total and extreme counts. The block takes one request at a time.
// done is high for one cycle with total_words and extreme_words; the receiver
// cannot stall, and busy falls in the cycle after done.
// cfg_we writes extreme_gap from cfg_wdata; write it only while busy is low.
// Reset returns the control to idle and extreme_gap to 45; the ring content
// is not cleared, since each request rewrites it before use.
module rank_sum_word_count_extremes import rswc_pkg::*; #(
  parameter int MAX_GROUP = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  size_t             size_a,
  input  size_t             size_b,
  output logic              busy,
  output logic              done,
  output coef_t             total_words,
  output coef_t             extreme_words,
  input  logic              cfg_we,
  input  gap_t              cfg_wdata
);

  localparam int L    = MAX_GROUP * MAX_GROUP + 1;
  localparam int SW   = $clog2(L);
  localparam int CW   = SW + 1;
  localparam int HD   = 2 * MAX_GROUP;
  localparam int HW   = $clog2(HD);
  localparam int JW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CMPW = (CW > GAP_W) ? CW : GAP_W;

  localparam logic [SW-1:0] LAST_T = SW'(L - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  gap_t          extreme_gap;
  logic [CW-1:0] a_r, b_r, ab_r, pass_j, m_r, deg_r;
  logic [SW-1:0] t;
  coef_t         acc_total, acc_extreme;

  coef_t ring_q [L];
  coef_t hist_q [HD];
  coef_t ring_tap [MAX_GROUP];
  coef_t coef_in, coef_out, sub_term, add_term;

  logic          running, last_pass;
  logic [CW-1:0] t_ext, a_c, b_c, j_dec, m_dec, twice_t, gap;
  logic [2*CW-1:0] ab_full;

  assign running = (state == ST_RUN);
  assign busy    = (state != ST_IDLE);
  assign done    = (state == ST_DONE);
  assign total_words   = acc_total;
  assign extreme_words = acc_extreme;

  // Ring of score cells and input history chain.
  for (genvar k = 0; k < L; k++) begin : g_ring
    rswc_cell u_cell (
      .clk     (clk),
      .advance (running),
      .d       ((k == 0) ? coef_out : ring_q[(k == 0) ? 0 : k - 1]),
      .q       (ring_q[k])
    );
  end

  for (genvar k = 0; k < HD; k++) begin : g_hist
    rswc_cell u_cell (
      .clk     (clk),
      .advance (running),
      .d       ((k == 0) ? coef_in : hist_q[(k == 0) ? 0 : k - 1]),
      .q       (hist_q[k])
    );
  end

  for (genvar k = 0; k < MAX_GROUP; k++) begin : g_tap
    assign ring_tap[k] = ring_q[k];
  end

  always_comb begin
    a_c = (size_a > SIZE_W'(MAX_GROUP)) ? CW'(MAX_GROUP) : CW'(size_a);
    b_c = (size_b > SIZE_W'(MAX_GROUP)) ? CW'(MAX_GROUP) : CW'(size_b);
    ab_full = a_c * b_c;
  end

  always_comb begin
    coef_in   = ring_q[L-1];
    t_ext     = CW'(t);
    j_dec     = pass_j - CW'(1);
    m_dec     = m_r - CW'(1);
    last_pass = (pass_j == a_r);
    sub_term  = (t_ext >= m_r) ? hist_q[m_dec[HW-1:0]] : '0;
    add_term  = (t_ext >= pass_j) ? ring_tap[j_dec[JW-1:0]] : '0;
    if (pass_j == '0) begin
      coef_out = (t == '0) ? coef_t'(1) : '0;
    end else if (t_ext > deg_r) begin
      coef_out = coef_in;
    end else begin
      coef_out = coef_in - sub_term + add_term;
    end
    twice_t = {t, 1'b0};
    gap     = (twice_t >= ab_r) ? (twice_t - ab_r) : (ab_r - twice_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extreme_gap <= GAP_RESET;
    end else if (cfg_we) begin
      extreme_gap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (t == LAST_T && last_pass) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      a_r         <= a_c;
      b_r         <= b_c;
      ab_r        <= CW'(ab_full);
      pass_j      <= '0;
      m_r         <= b_c;
      deg_r       <= '0;
      t           <= '0;
      acc_total   <= '0;
      acc_extreme <= '0;
    end else if (running) begin
      if (last_pass && t_ext <= ab_r) begin
        acc_total <= acc_total + coef_out;
        if (CMPW'(gap) >= CMPW'(extreme_gap)) begin
          acc_extreme <= acc_extreme + coef_out;
        end
      end
      if (t == LAST_T) begin
        t      <= '0;
        pass_j <= pass_j + CW'(1);
        m_r    <= m_r + CW'(1);
        deg_r  <= deg_r + b_r;
      end else begin
        t <= t + SW'(1);
      end
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench for rank_sum_word_count_extremes: directed and random size pairs under
// several extreme_gap settings, checked against a word-count recurrence predictor.
// Depends on rswc_pkg and the rank_sum_word_count_extremes RTL.
module tb_top;
  import rswc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GROUP   = 16;
  localparam int SCORE_DEPTH = MAX_GROUP * MAX_GROUP + 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RESET_CYCLES = 6;

  typedef struct packed {
    size_t a;
    size_t b;
  } size_pair_t;

  typedef struct packed {
    coef_t total;
    coef_t extreme;
  } word_counts_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  size_t size_a = '0;
  size_t size_b = '0;
  logic  busy;
  logic  done;
  coef_t total_words;
  coef_t extreme_words;
  logic  cfg_we = 1'b0;
  gap_t  cfg_wdata = '0;

  size_pair_t   pending_sizes[$];
  word_counts_t expected_counts[$];
  gap_t         gap_model;
  logic         took_item = 1'b0;
  int           idle_left = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  rank_sum_word_count_extremes #(.MAX_GROUP(MAX_GROUP)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .size_a       (size_a),
    .size_b       (size_b),
    .busy         (busy),
    .done         (done),
    .total_words  (total_words),
    .extreme_words(extreme_words),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // f(i,j,s) = f(i,j-1,s-i) + f(i-1,j,s), rows built up over i
  function automatic word_counts_t predict_word_counts(size_t sa, size_t sb, gap_t thr);
    int unsigned prev_row [0:MAX_GROUP][0:SCORE_DEPTH-1];
    int unsigned this_row [0:MAX_GROUP][0:SCORE_DEPTH-1];
    int unsigned total;
    int unsigned extreme;
    int ga, gb, ab, score_gap;
    word_counts_t res;
    ga = (sa > MAX_GROUP) ? MAX_GROUP : int'(sa);
    gb = (sb > MAX_GROUP) ? MAX_GROUP : int'(sb);
    ab = ga * gb;
    for (int j = 0; j <= MAX_GROUP; j++)
      for (int s = 0; s < SCORE_DEPTH; s++)
        prev_row[j][s] = (s == 0) ? 1 : 0;
    for (int i = 1; i <= ga; i++) begin
      for (int j = 0; j <= gb; j++)
        for (int s = 0; s < SCORE_DEPTH; s++) begin
          this_row[j][s] = prev_row[j][s];
          if (j > 0 && s >= i)
            this_row[j][s] += this_row[j-1][s-i];
        end
      prev_row = this_row;
    end
    total = 0;
    extreme = 0;
    for (int s = 0; s <= ab; s++) begin
      score_gap = (2 * s >= ab) ? 2 * s - ab : ab - 2 * s;
      total += prev_row[gb][s];
      if (score_gap >= int'(thr))
        extreme += prev_row[gb][s];
    end
    res.total = coef_t'(total);
    res.extreme = coef_t'(extreme);
    return res;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10)
      return 0;
    else if (r < 17)
      return $urandom_range(1, 4);
    else
      return $urandom_range(20, 250);
  endfunction

  function automatic size_t random_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13)
      return size_t'($urandom_range(0, 6));
    else if (r < 17)
      return size_t'($urandom_range(7, MAX_GROUP));
    else
      return size_t'($urandom_range(MAX_GROUP + 1, 31));
  endfunction

  // driver: hold start until the transfer, then idle or take the next pair
  always @(negedge clk) begin
    size_pair_t nxt;
    logic  next_start;
    size_t na, nb;
    if (rst) begin
      start <= 1'b0;
      size_a <= '0;
      size_b <= '0;
    end else begin
      next_start = start;
      na = size_a;
      nb = size_b;
      if (!start || took_item) begin
        if (start)
          idle_left = pick_idle();
        if (idle_left > 0) begin
          idle_left--;
          next_start = 1'b0;
          na = size_t'($urandom);
          nb = size_t'($urandom);
        end else if (pending_sizes.size() > 0) begin
          nxt = pending_sizes.pop_front();
          next_start = 1'b1;
          na = nxt.a;
          nb = nxt.b;
        end else begin
          next_start = 1'b0;
        end
      end
      start <= next_start;
      size_a <= na;
      size_b <= nb;
    end
  end

  // monitor: predict on each transfer, check each done strobe
  always @(posedge clk) begin
    word_counts_t want;
    if (rst) begin
      gap_model <= GAP_RESET;
      took_item <= 1'b0;
    end else begin
      took_item <= start && !busy;
      if (cfg_we)
        gap_model <= cfg_wdata;
      if (done) begin
        if (expected_counts.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: total %0d extreme %0d",
                   $time, total_words, extreme_words);
        end else begin
          want = expected_counts.pop_front();
          if (total_words !== want.total) begin
            error_count++;
            $display("%0t total_words: expected %0d, got %0d",
                     $time, want.total, total_words);
          end
          if (extreme_words !== want.extreme) begin
            error_count++;
            $display("%0t extreme_words: expected %0d, got %0d",
                     $time, want.extreme, extreme_words);
          end
        end
      end
      if (start && !busy)
        expected_counts.push_back(predict_word_counts(size_a, size_b, gap_model));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_sizes(int a, int b);
    size_pair_t p;
    p.a = size_t'(a);
    p.b = size_t'(b);
    pending_sizes.push_back(p);
  endtask

  task automatic push_random(int n);
    for (int k = 0; k < n; k++)
      push_sizes(random_size(), random_size());
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_sizes.size() != 0 || start || expected_counts.size() != 0 || busy)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gap(gap_t value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= gap_t'($urandom);
    @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset threshold: empty groups, extremes, saturation
    push_sizes(0, 0);
    push_sizes(0, 16);
    push_sizes(16, 0);
    push_sizes(1, 1);
    push_sizes(1, 16);
    push_sizes(16, 1);
    push_sizes(16, 16);
    push_sizes(31, 31);
    push_sizes(17, 2);
    push_sizes(2, 31);
    push_sizes(5, 5);
    push_sizes(10, 9);
    push_sizes(3, 12);
    push_sizes(8, 8);
    push_sizes(16, 15);
    push_sizes(0, 31);

    write_gap(gap_t'(0));
    push_sizes(0, 0);
    push_sizes(0, 7);
    push_sizes(4, 4);
    push_random(20);

    write_gap(gap_t'(511));
    push_sizes(16, 16);
    push_sizes(3, 3);
    push_random(20);

    write_gap(gap_t'(256));
    push_sizes(16, 16);
    push_sizes(16, 31);
    push_sizes(15, 16);
    push_random(20);

    for (int ph = 0; ph < 3; ph++) begin
      write_gap(gap_t'($urandom_range(1, 255)));
      push_sizes(6, 6);
      push_random(14);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> rank_sum_word_count_extremes.f
hw/rtl/rswc_pkg.sv
hw/rtl/rswc_cell.sv
hw/rtl/rank_sum_word_count_extremes.sv
test/tb_top.sv
